### rtl/core/seconds_to_calendar_date_unit_assert.svh
// Assertion macros for the seconds to calendar date unit.
`ifndef SECONDS_TO_CALENDAR_DATE_UNIT_ASSERT_SVH
`define SECONDS_TO_CALENDAR_DATE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define STCD_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("stcd check failed");
`define STCD_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("stcd reset check failed");
`else
`define STCD_ASSERT(label, prop)
`define STCD_ASSERT_ALWAYS(label, prop)
`endif
`endif

### rtl/core/stcd_pkg.sv
// Constants and helper functions for the seconds to calendar date unit.
package stcd_pkg;
   localparam int unsigned DAY_RECIP    = 50903317; // 2^35 / 675, rounded up
   localparam int unsigned DAY_SHIFT    = 35;
   localparam int unsigned SECS_PER_DAY = 86400;
   localparam int unsigned CYCLE_RECIP  = 91868;    // 2^27 / 1461, rounded up
   localparam int unsigned CYCLE_DAYS   = 1461;
   localparam int unsigned WEEK_RECIP   = 74899;    // 2^19 / 7, rounded up
   localparam int unsigned WEEK_OFFSET  = 6;
   localparam int unsigned HOUR_RECIP   = 9321;     // 2^21 / 225, rounded up
   localparam int unsigned SECS_PER_HR  = 3600;
   localparam int unsigned MIN_RECIP    = 1093;     // 2^14 / 15, rounded up
   localparam int unsigned SECS_PER_MIN = 60;

   localparam logic [8:0] MONTH_START [12] = '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
                                              9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
      logic [8:0] s;
      s = MONTH_START[idx];
      if (leap && idx >= 4'd2) begin
         s = s + 9'd1;
      end
      return s;
   endfunction
endpackage

### rtl/core/seconds_to_calendar_date_unit.sv
// Seconds to calendar date unit: converts a seconds count into date, time and weekday.
// An item on the req_ channel carries a 32-bit count of seconds since year 00, January 1,
// midnight. For each accepted item exactly one item leaves on the rsp_ channel with year,
// month, day, hour, minute, second and weekday. Every year divisible by four is a leap year.
// The unit is a seven-stage pipeline: the divisions by the day, the four-year cycle, the
// hour, the minute and the week are multiplications by reciprocals, with no two multipliers
// in series. Items pass registers s1 to s7 before rsp_tvalid, and one item can enter in
// every cycle that the pipeline advances. It advances as a whole whenever the output
// register is empty or is being taken; when the receiver holds rsp_tready low with a result
// waiting, req_tready falls and every stage keeps its item, so nothing is lost or repeated.
// Reset clears all valid bits; the unit holds no other state and needs no setup.
module seconds_to_calendar_date_unit
   import stcd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // elapsed_seconds[31:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // year, month, day, hour, minute, second, weekday, zeros
);
`include "seconds_to_calendar_date_unit_assert.svh"

   logic [6:0]  vld_ff, vld_in;
   logic        advance;

   logic [31:0] s1_secs_ff;
   logic [31:0] s2_secs_ff;
   logic [15:0] s2_q_ff;
   logic [16:0] s3_tod_ff;
   logic [15:0] s3_q_ff;
   logic [5:0]  s3_c_ff;
   logic [14:0] s3_wq_ff;
   logic [16:0] s4_tod_ff;
   logic [4:0]  s4_hour_ff;
   logic [10:0] s4_r_ff;
   logic [5:0]  s4_c_ff;
   logic [2:0]  s4_wd_ff;
   logic [11:0] s5_rs_ff;
   logic [4:0]  s5_hour_ff;
   logic [7:0]  s5_year_ff;
   logic [8:0]  s5_doy_ff;
   logic        s5_leap_ff;
   logic [2:0]  s5_wd_ff;
   logic [11:0] s6_rs_ff;
   logic [5:0]  s6_min_ff;
   logic [4:0]  s6_hour_ff;
   logic [7:0]  s6_year_ff;
   logic [3:0]  s6_month_ff;
   logic [4:0]  s6_day_ff;
   logic [2:0]  s6_wd_ff;
   logic [5:0]  s7_sec_ff;
   logic [5:0]  s7_min_ff;
   logic [4:0]  s7_hour_ff;
   logic [7:0]  s7_year_ff;
   logic [3:0]  s7_month_ff;
   logic [4:0]  s7_day_ff;
   logic [2:0]  s7_wd_ff;

   logic [50:0] p_day;
   logic [31:0] p_tod;
   logic [32:0] p_cyc;
   logic [16:0] q6;
   logic [33:0] p_week;
   logic [25:0] p_hour;
   logic [15:0] p_r;
   logic [16:0] p_wd;
   logic [16:0] p_rs;
   logic [1:0]  yc;
   logic [8:0]  doy;
   logic [20:0] p_min;
   logic [3:0]  mo_idx;
   logic [8:0]  day0;
   logic [11:0] p_sec;

   assign advance    = ~vld_ff[6] | rsp_tready;
   assign req_tready = advance;
   assign vld_in     = {vld_ff[5:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      p_day  = 51'(s1_secs_ff[31:7]) * 51'(DAY_RECIP);
      p_tod  = s2_secs_ff - 32'(s2_q_ff) * 32'(SECS_PER_DAY);
      p_cyc  = 33'(s2_q_ff) * 33'(CYCLE_RECIP);
      q6     = 17'(s2_q_ff) + 17'(WEEK_OFFSET);
      p_week = 34'(q6) * 34'(WEEK_RECIP);
      p_hour = 26'(s3_tod_ff[16:4]) * 26'(HOUR_RECIP);
      p_r    = s3_q_ff - 16'(s3_c_ff) * 16'(CYCLE_DAYS);
      p_wd   = (17'(s3_q_ff) + 17'(WEEK_OFFSET)) - 17'(s3_wq_ff) * 17'd7;
      p_rs   = s4_tod_ff - 17'(s4_hour_ff) * 17'(SECS_PER_HR);
      if (s4_r_ff < 11'd366) begin
         yc  = 2'd0;
         doy = s4_r_ff[8:0];
      end else if (s4_r_ff < 11'd731) begin
         yc  = 2'd1;
         doy = 9'(s4_r_ff - 11'd366);
      end else if (s4_r_ff < 11'd1096) begin
         yc  = 2'd2;
         doy = 9'(s4_r_ff - 11'd731);
      end else begin
         yc  = 2'd3;
         doy = 9'(s4_r_ff - 11'd1096);
      end
      p_min  = 21'(s5_rs_ff[11:2]) * 21'(MIN_RECIP);
      mo_idx = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (s5_doy_ff >= month_start(s5_leap_ff, 4'(i))) begin
            mo_idx = 4'(i);
         end
      end
      day0  = s5_doy_ff - month_start(s5_leap_ff, mo_idx);
      p_sec = s6_rs_ff - 12'(s6_min_ff) * 12'(SECS_PER_MIN);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_secs_ff  <= req_tdata;
         s2_secs_ff  <= s1_secs_ff;
         s2_q_ff     <= p_day[50:35];
         s3_tod_ff   <= p_tod[16:0];
         s3_q_ff     <= s2_q_ff;
         s3_c_ff     <= p_cyc[32:27];
         s3_wq_ff    <= p_week[33:19];
         s4_tod_ff   <= s3_tod_ff;
         s4_hour_ff  <= p_hour[25:21];
         s4_r_ff     <= p_r[10:0];
         s4_c_ff     <= s3_c_ff;
         s4_wd_ff    <= p_wd[2:0];
         s5_rs_ff    <= p_rs[11:0];
         s5_hour_ff  <= s4_hour_ff;
         s5_year_ff  <= {s4_c_ff, yc};
         s5_doy_ff   <= doy;
         s5_leap_ff  <= (yc == 2'd0);
         s5_wd_ff    <= s4_wd_ff;
         s6_rs_ff    <= s5_rs_ff;
         s6_min_ff   <= p_min[19:14];
         s6_hour_ff  <= s5_hour_ff;
         s6_year_ff  <= s5_year_ff;
         s6_month_ff <= mo_idx + 4'd1;
         s6_day_ff   <= 5'(day0 + 9'd1);
         s6_wd_ff    <= s5_wd_ff;
         s7_sec_ff   <= p_sec[5:0];
         s7_min_ff   <= s6_min_ff;
         s7_hour_ff  <= s6_hour_ff;
         s7_year_ff  <= s6_year_ff;
         s7_month_ff <= s6_month_ff;
         s7_day_ff   <= s6_day_ff;
         s7_wd_ff    <= s6_wd_ff;
      end
   end

   assign rsp_tvalid = vld_ff[6];
   assign rsp_tdata  = {3'd0, s7_wd_ff, s7_sec_ff, s7_min_ff, s7_hour_ff, s7_day_ff,
                        s7_month_ff, s7_year_ff};

   `STCD_ASSERT(a_month_range, rsp_tvalid |-> (s7_month_ff >= 4'd1 && s7_month_ff <= 4'd12))
   `STCD_ASSERT(a_day_range, rsp_tvalid |-> (s7_day_ff != 5'd0))
   `STCD_ASSERT(a_time_range, rsp_tvalid |-> (s7_hour_ff < 5'd24 && s7_min_ff < 6'd60 && s7_sec_ff < 6'd60))
   `STCD_ASSERT(a_weekday_range, rsp_tvalid |-> (s7_wd_ff < 3'd7))
   `STCD_ASSERT_ALWAYS(a_reset_empty, reset |=> (vld_ff == 7'd0))
endmodule

### verif/tb_top.sv
// Self-checking testbench for the seconds to calendar date unit.
`timescale 1ns / 1ps
module tb_top;
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   typedef struct packed {
      logic [2:0] weekday;
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [7:0] year;
   } date_type;

   localparam int unsigned WATCHDOG_LIMIT = 20000;

   logic [31:0] pending_secs[$];
   date_type    expected_dates[$];
   int          error_count;
   int unsigned idle_cycles;
   int unsigned cycle_count;
   bit          stimulus_done;

   seconds_to_calendar_date_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   function automatic date_type calendar_of(input logic [31:0] secs);
      date_type    d;
      int unsigned tod, daynum, rest, yr, mo, len;
      int unsigned mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      tod = secs % 86400;
      daynum = secs / 86400 + 1;
      rest = daynum;
      yr = 0;
      mo = 1;
      forever begin
         len = (yr % 4 == 0) ? 366 : 365;
         if (rest <= len) break;
         rest -= len;
         yr++;
      end
      forever begin
         len = mlen[mo - 1] + ((mo == 2 && yr % 4 == 0) ? 1 : 0);
         if (rest <= len || mo >= 12) break;
         rest -= len;
         mo++;
      end
      d.year = yr[7:0];
      d.month = mo[3:0];
      d.day = rest[4:0];
      d.hour = 5'(tod / 3600);
      d.minute = 6'((tod % 3600) / 60);
      d.second = 6'(tod % 60);
      d.weekday = 3'((daynum + 5) % 7);
      return d;
   endfunction

   function automatic bit stall_now();
      return (cycle_count > 800 && cycle_count < 1800) ? 1'b0 : ($urandom_range(99) < 37);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cyc;
      cyc = 1461 * 86400;
      pending_secs.push_back(32'd0);
      pending_secs.push_back(32'hFFFF_FFFF);
      pending_secs.push_back(32'd86399);
      pending_secs.push_back(32'd86400);
      pending_secs.push_back(32'd31 * 86400 - 1);
      pending_secs.push_back(32'd59 * 86400);
      pending_secs.push_back(32'd60 * 86400 - 1);
      pending_secs.push_back(32'd60 * 86400);
      pending_secs.push_back(32'd366 * 86400 - 1);
      pending_secs.push_back(32'd366 * 86400);
      pending_secs.push_back(32'd1461 * 86400 - 1);
      pending_secs.push_back(32'd1461 * 86400);
      pending_secs.push_back(32'd36525 * 86400 + 59 * 86400);
      pending_secs.push_back(32'd36525 * 86400 + 60 * 86400);
      pending_secs.push_back(32'hAAAA_AAAA);
      pending_secs.push_back(32'h5555_5555);
      pending_secs.push_back(32'h8000_0000);
      pending_secs.push_back(32'h7FFF_FFFF);
      pending_secs.push_back(32'd3599);
      pending_secs.push_back(32'd3600);
      for (int i = 0; i < 1650; i++) begin
         case ($urandom_range(3))
            0: pending_secs.push_back($urandom());
            1: pending_secs.push_back(32'd86400 * $urandom_range(49710) + $urandom_range(1)
                  * 86399);
            2: pending_secs.push_back(cyc * $urandom_range(33) + $urandom_range(cyc - 1));
            default: pending_secs.push_back(32'hFFFF_FFFF - $urandom_range(200000));
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count < 7) begin
         reset <= 1'b1;
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         rsp_tready <= 1'b0;
      end else begin
         reset <= 1'b0;
         rsp_tready <= !stall_now();
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) expected_dates.push_back(calendar_of(req_tdata));
            if (pending_secs.size() > 0 && !stall_now()) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_secs.pop_front();
            end else begin
               req_tvalid <= 1'b0;
               if (pending_secs.size() == 0 && !reset) stimulus_done <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      date_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[36:0];
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, got);
            error_count <= error_count + 1;
         end else begin
            want = expected_dates.pop_front();
            if (got !== want || rsp_tdata[39:37] !== 3'b000) begin
               $display("%0t: mismatch, expected y%0d m%0d d%0d %0d:%0d:%0d w%0d, actual %h",
                  $time, want.year, want.month, want.day, want.hour, want.minute,
                  want.second, want.weekday, rsp_tdata);
               error_count <= error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      error_count = 0;
      idle_cycles = 0;
      cycle_count = 0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      fork
         begin
            wait (stimulus_done && !req_tvalid && expected_dates.size() == 0);
            repeat (20) @(posedge clock);
         end
         wait (idle_cycles >= WATCHDOG_LIMIT);
      join_any
      if (error_count == 0 && idle_cycles < WATCHDOG_LIMIT && expected_dates.size() == 0
            && !rsp_tvalid) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
